@@ design/wma_pkg.sv @@
// ----------------------------------------------------------------------------
// wma_pkg
// Shared widths, constants and controller/datapath interface types for the
// windowed moving average filter.
// ----------------------------------------------------------------------------
package wma_pkg;

	localparam int DEPTH       = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int POS_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W       = $clog2(DEPTH + 1);
	localparam int SUM_W       = SAMPLE_BITS + POS_W;
	localparam int CNT_W       = $clog2(SUM_W);
	localparam int VALUE_W     = 16;
	localparam int CFG_W       = 5;

	localparam logic [CFG_W-1:0] WLEN_RESET = CFG_W'(16);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [POS_W-1:0]       pos_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic div_step;
		logic out_load;
	} wma_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic filling;
	} wma_stat_t;

	// Clamp a written window length into 1 .. DEPTH.
	function automatic len_t wma_eff_len(input logic [CFG_W-1:0] wlen);
		len_t len;
		if (wlen == '0) begin
			len = len_t'(1);
		end else if (32'(wlen) > DEPTH) begin
			len = len_t'(DEPTH);
		end else begin
			len = len_t'(wlen);
		end
		return len;
	endfunction

endpackage

@@ design/wma_ctrl.sv @@
// ----------------------------------------------------------------------------
// wma_ctrl
// Sequencer: accepts a sample, steps the datapath through ring read, sum
// update and restoring division, and owns the output valid flag.
// ----------------------------------------------------------------------------
module wma_ctrl
	import wma_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  wma_stat_t stat,
	output wma_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.update   = (state_q == ST_UPDATE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_OUT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					cnt_q   <= '0;
					state_q <= stat.filling ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CNT_W'(SUM_W)))
		else $error("divider step count out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_W'(SUM_W - 1)) |=> (state_q == ST_OUT))
		else $error("division did not finish after full step count");

endmodule

@@ design/wma_dp.sv @@
// ----------------------------------------------------------------------------
// wma_dp
// Datapath: sample ring, running sum, fill count, write position, window
// length register, bit-serial restoring divider and result register.
// ----------------------------------------------------------------------------
module wma_dp
	import wma_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  sample_t            in_sample,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  wma_cmd_t           cmd,
	output wma_stat_t          stat,
	output logic [VALUE_W-1:0] res_value,
	output logic               res_status
);

	sample_t ring [DEPTH];

	len_t    len_q;
	len_t    fill_q;
	pos_t    wp_q;
	sum_t    sum_q;
	sample_t sample_q;
	sample_t old_q;
	logic    fill_path_q;
	sum_t    dvd_q;
	len_t    rem_q;
	logic [VALUE_W-1:0] value_q;
	logic    status_q;

	logic         filling;
	sum_t         sum_fill;
	sum_t         sum_full;
	logic [LEN_W:0] trial;
	logic         take;
	logic [LEN_W:0] wp_inc;

	assign filling  = (fill_q < len_q);
	assign sum_fill = sum_q + sum_t'(sample_q);
	assign sum_full = sum_q - sum_t'(old_q) + sum_t'(sample_q);
	assign trial    = {rem_q, dvd_q[SUM_W-1]};
	assign take     = (trial >= {1'b0, len_q});
	assign wp_inc   = (LEN_W+1)'(wp_q) + (LEN_W+1)'(1);

	assign stat.filling = filling;
	assign res_value    = value_q;
	assign res_status   = status_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
			old_q    <= ring[wp_q];
		end
		if (cmd.update) begin
			ring[wp_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= wma_eff_len(WLEN_RESET);
			fill_q <= '0;
			wp_q   <= '0;
			sum_q  <= '0;
		end else if (cfg_we) begin
			len_q  <= wma_eff_len(cfg_wdata);
			fill_q <= '0;
			wp_q   <= '0;
			sum_q  <= '0;
		end else if (cmd.update) begin
			if (filling) begin
				fill_q <= fill_q + len_t'(1);
				sum_q  <= sum_fill;
			end else begin
				sum_q  <= sum_full;
			end
			if (wp_inc >= {1'b0, len_q}) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			fill_path_q <= filling;
			dvd_q       <= sum_full;
			rem_q       <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], take};
			rem_q <= take ? len_t'(trial - {1'b0, len_q}) : len_t'(trial);
		end
		if (cmd.out_load) begin
			value_q  <= fill_path_q ? VALUE_W'(sample_q) : dvd_q[VALUE_W-1:0];
			status_q <= !fill_path_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_q)
		else $error("fill count beyond window length");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_t'(wp_q) < len_q) || (len_q == len_t'(DEPTH) && wp_q <= pos_t'(DEPTH - 1)))
		else $error("write position outside window");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !filling && !cfg_we) |=> (fill_q == len_q))
		else $error("full window lost its fill count");

endmodule

@@ design/windowed_moving_average.sv @@
// ----------------------------------------------------------------------------
// windowed_moving_average
// Boxcar moving average over the last window_len unsigned samples.
// ----------------------------------------------------------------------------
// One sample in, one result out. While the window fills, the raw sample is
// returned with tuser 0; once full, the truncated mean of the last window_len
// samples is returned with tuser 1. A sample goes through capture and ring read,
// ring write/sum update, 20 steps of the one-bit-per-cycle divider (only once
// the window is full) and result load; the divider sets the rate.
// A result waiting in the output register does not block the next sample.
// Writing window_len (clamped to 1..16) restarts the window; write it only
// while the block is idle.
module windowed_moving_average
	import wma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [15:0] sample
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [VALUE_W-1:0]   m_axis_tdata,   // [15:0] value
	output logic                 m_axis_tuser,   // [0] status
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data        // window_len
);

	wma_cmd_t  cmd;
	wma_stat_t stat;

	assign cfg_ready = 1'b1;

	wma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wma_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_sample  (sample_t'(s_axis_tdata)),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_wdata  (cfg_data),
		.cmd        (cmd),
		.stat       (stat),
		.res_value  (m_axis_tdata),
		.res_status (m_axis_tuser)
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed moving average filter. Streams samples
// in bursts under a stalling receiver, rewrites the window length between
// runs (including zero and lengths above the ring depth) and checks every
// result against a behavioural boxcar average kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
	import wma_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               status;
	} avg_result_t;

	class avg_scoreboard;
		sample_t           ring [DEPTH];
		sum_t              window_sum;
		logic [4:0]        fill;
		pos_t              wpos;
		logic [CFG_W-1:0]  wlen;
		avg_result_t       pending_q [$];
		int                mismatches;
		int                checked;
		int                averaged;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wlen = WLEN_RESET;
			restart_window(WLEN_RESET);
			mismatches = 0;
			checked = 0;
			averaged = 0;
		endfunction

		function void restart_window(logic [CFG_W-1:0] len_cfg);
			wlen = len_cfg;
			window_sum = '0;
			fill = '0;
			wpos = '0;
		endfunction

		function void note_sample(sample_t s);
			int          len;
			int          p;
			avg_result_t r;
			len = int'(wlen);
			if (len == 0) len = 1;
			if (len > DEPTH) len = DEPTH;
			p = int'(wpos);
			if (p >= len) p = 0;
			if (int'(fill) < len) begin
				fill = fill + 5'd1;
				window_sum = window_sum + sum_t'(s);
				r.value = s;
				r.status = 1'b0;
			end else begin
				window_sum = window_sum - sum_t'(ring[p]) + sum_t'(s);
				r.value = VALUE_W'(int'(window_sum) / int'(fill));
				r.status = 1'b1;
			end
			ring[p] = s;
			p++;
			if (p >= len) p = 0;
			wpos = pos_t'(p);
			pending_q.push_back(r);
		endfunction

		function void check_result(logic [VALUE_W-1:0] value, logic status);
			avg_result_t want;
			if (pending_q.size() == 0) begin
				if (mismatches < 10)
					$display("[%0t] unexpected result value=%h status=%b", $realtime, value,
						status);
				mismatches++;
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (want.status) averaged++;
			if (value !== want.value || status !== want.status) begin
				if (mismatches < 10)
					$display("[%0t] mismatch: value exp %h got %h, status exp %b got %b",
						$realtime, want.value, value, want.status, status);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [15:0]        s_axis_tdata = '0;    // [15:0] sample
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [VALUE_W-1:0] m_axis_tdata;         // [15:0] value
	logic               m_axis_tuser;         // [0] status
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data = '0;

	avg_scoreboard sb;
	int            cycle_count = 0;
	int            samples_sent = 0;
	int            window_writes = 0;
	int            stall_mode = 0;
	int            stall_tick = 0;

	windowed_moving_average dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("windowed_moving_average test failed");
			$finish;
		end
	end

	// result side: m_axis_tready follows a randomly re-chosen stall pattern
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ((stall_tick % 29) >= 20);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_sample(input sample_t s);
		s_axis_tdata <= s;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(s);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic pause_input(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] len_cfg);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data <= len_cfg;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.restart_window(len_cfg);
		window_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return sample_t'($urandom_range(0, 15));
			3: return sample_t'($urandom_range(16'hFFF0, 16'hFFFF));
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_run(input int n);
		int left;
		int burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left) burst = left;
			repeat (burst) send_sample(pick_sample());
			left -= burst;
			if (left > 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: ;
					4, 5, 6, 7: pause_input($urandom_range(1, 6));
					8: pause_input($urandom_range(15, 30));
					default: drain_results();
				endcase
			end
		end
	endtask

	initial begin
		int                target;
		logic [CFG_W-1:0]  len_cfg;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero length behaves as one
		write_window(5'd0);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h0001);
		write_window(5'd2);
		repeat (3) send_sample(16'hFFFF);
		// oversize length clamps to the full ring; largest possible sum
		write_window(5'd31);
		repeat (17) send_sample(16'hFFFF);

		target = samples_sent + RANDOM_ITEMS;
		while (samples_sent < target) begin
			case ($urandom_range(0, 5))
				0: len_cfg = CFG_W'($urandom_range(0, 4));
				1: len_cfg = CFG_W'(DEPTH);
				2: len_cfg = CFG_W'($urandom_range(17, 31));
				3: len_cfg = CFG_W'(1);
				default: len_cfg = CFG_W'($urandom_range(0, 31));
			endcase
			write_window(len_cfg);
			if ($urandom_range(0, 4) == 0)
				send_run($urandom_range(1, 8));   // short run; the window may restart before it fills
			else
				send_run($urandom_range(20, 120));
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d samples over %0d window length writes, %0d results checked",
			samples_sent, window_writes, sb.checked);
		$display("%0d full-window averages, %0d mismatches", sb.averaged, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("windowed_moving_average test passed");
		end else begin
			$display("windowed_moving_average test failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/wma_pkg.sv
design/wma_ctrl.sv
design/wma_dp.sv
design/windowed_moving_average.sv
verif/tb_top.sv
